@@ design/roi_gray_mean_statistics_core_defines.svh @@
// ----------------------------------------------------------------------------
// roi gray mean statistics: assertion macros
// shared property forms for the block's checkers
// ----------------------------------------------------------------------------
`ifndef ROI_GRAY_MEAN_STATISTICS_CORE_DEFINES_SVH
`define ROI_GRAY_MEAN_STATISTICS_CORE_DEFINES_SVH

// same-cycle implication
`define RGMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgms same-cycle check failed");

// next-cycle implication
`define RGMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgms next-cycle check failed");

`endif

@@ design/rgms_pkg.sv @@
// ----------------------------------------------------------------------------
// rgms_pkg
// types and fixed constants of the roi gray mean statistics block
// ----------------------------------------------------------------------------
package rgms_pkg;

   localparam int NUM_WIN    = 3;
   localparam int WIN_IDX_W  = 2;
   localparam int ORIGIN_W   = 13;
   localparam int SIZE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int CHAN_W     = 8;
   localparam int GRAY_W     = 8;
   localparam int SUM_W      = 24;
   localparam int COUNT_W    = 16;
   localparam int MEAN_W     = 16;
   localparam int FRAC_W     = 8;

   // bt.601 weights, 14-bit fixed point
   localparam int COEF_W     = 14;
   localparam int PROD_W     = CHAN_W + COEF_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int GRAY_SHIFT = 14;
   localparam logic [ACC_W-1:0]  GRAY_ROUND = ACC_W'(8192);
   localparam logic [COEF_W-1:0] COEF_BLUE  = COEF_W'(1868);
   localparam logic [COEF_W-1:0] COEF_GREEN = COEF_W'(9617);
   localparam logic [COEF_W-1:0] COEF_RED   = COEF_W'(4899);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ORIGIN_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ORIGIN_Y  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_ORIGIN_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_ORIGIN_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THIRD_ORIGIN_X  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_THIRD_ORIGIN_Y  = 3'd7;

   // register reset values
   localparam logic [SIZE_W-1:0]          WIDTH_RESET  = SIZE_W'(40);
   localparam logic [SIZE_W-1:0]          HEIGHT_RESET = SIZE_W'(40);
   localparam logic signed [ORIGIN_W-1:0] ORG_X0_RESET = ORIGIN_W'(100);
   localparam logic signed [ORIGIN_W-1:0] ORG_Y0_RESET = ORIGIN_W'(80);
   localparam logic signed [ORIGIN_W-1:0] ORG_X1_RESET = ORIGIN_W'(160);
   localparam logic signed [ORIGIN_W-1:0] ORG_Y1_RESET = ORIGIN_W'(120);
   localparam logic signed [ORIGIN_W-1:0] ORG_X2_RESET = ORIGIN_W'(200);
   localparam logic signed [ORIGIN_W-1:0] ORG_Y2_RESET = ORIGIN_W'(160);

   localparam logic [WIN_IDX_W-1:0] LAST_WIN = WIN_IDX_W'(NUM_WIN - 1);

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [MEAN_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ design/roi_gray_mean_statistics_core.sv @@
// No pixel item is taken before the last is through: after acceptance a single
// 8x14 multiplier builds the gray value in four accumulate steps, then one
// shared set of window compares and one adder visit the three windows in
// three steps, and req_ready returns. The item that carries frame_end first
// produces three result items, one per window in order; each valid window
// runs through the restoring divider, an invalid one skips it, and a result
// waits only for the rsp register to be free. The next frame's first pixel
// is taken as soon as the third result is loaded, while it still waits to
// be taken. Configuration writes are accepted in every cycle and must only
// be made while the block is idle.
// ----------------------------------------------------------------------------
// roi_gray_mean_statistics_core
// per-frame mean gray of three rectangular windows over a bgra pixel stream
// ----------------------------------------------------------------------------
module roi_gray_mean_statistics_core #(
   parameter int MAX_IMAGE_SIDE  = 4096,
   parameter int MAX_WINDOW_SIDE = 255
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rgms_pkg::CHAN_W-1:0]        req_blue,
   input  logic [rgms_pkg::CHAN_W-1:0]        req_green,
   input  logic [rgms_pkg::CHAN_W-1:0]        req_red,
   input  logic [rgms_pkg::CHAN_W-1:0]        req_alpha,
   input  logic                               req_line_end,
   input  logic                               req_frame_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rgms_pkg::WIN_IDX_W-1:0]     rsp_window_index,
   output logic [rgms_pkg::MEAN_W-1:0]        rsp_mean_gray,
   output logic                               rsp_window_valid,
   output logic                               rsp_last_window,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rgms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rgms_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_IMAGE_SIDE + 1);
   localparam int SIDE_W = $clog2(MAX_WINDOW_SIDE + 1);
   localparam int AREA_W = 2 * SIDE_W;
   localparam int CMP_W  = ((CNT_W > rgms_pkg::ORIGIN_W) ? CNT_W : rgms_pkg::ORIGIN_W) + 2;
   localparam int AC_W   = (AREA_W > rgms_pkg::COUNT_W) ? AREA_W : rgms_pkg::COUNT_W;
   localparam logic [CNT_W-1:0]  IMG_LIMIT = CNT_W'(MAX_IMAGE_SIDE);
   localparam logic [SIDE_W-1:0] SIDE_MAX  = SIDE_W'(MAX_WINDOW_SIDE);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_GRAY   = 6'b000010,
      ST_WIN    = 6'b000100,
      ST_LAUNCH = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   // configuration
   logic [rgms_pkg::SIZE_W-1:0]          width_ff;
   logic [rgms_pkg::SIZE_W-1:0]          height_ff;
   logic signed [rgms_pkg::ORIGIN_W-1:0] org_x_ff [rgms_pkg::NUM_WIN];
   logic signed [rgms_pkg::ORIGIN_W-1:0] org_y_ff [rgms_pkg::NUM_WIN];

   // sequencer and item registers
   state_type                     state_ff, state_in;
   logic [rgms_pkg::WIN_IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]              col_ff, col_in;
   logic [CNT_W-1:0]              row_ff, row_in;
   logic [CNT_W-1:0]              pix_col_ff, pix_col_in;
   logic [CNT_W-1:0]              pix_row_ff, pix_row_in;
   logic                          pix_in_img_ff, pix_in_img_in;
   logic                          pix_frame_end_ff, pix_frame_end_in;
   logic [rgms_pkg::CHAN_W-1:0]   pix_b_ff, pix_b_in;
   logic [rgms_pkg::CHAN_W-1:0]   pix_g_ff, pix_g_in;
   logic [rgms_pkg::CHAN_W-1:0]   pix_r_ff, pix_r_in;
   logic [rgms_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [rgms_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [AREA_W-1:0]             area_ff;
   logic                          res_ok_ff, res_ok_in;
   logic [rgms_pkg::MEAN_W-1:0]   mean_ff, mean_in;

   // window accumulators
   logic [rgms_pkg::SUM_W-1:0]    sums_ff   [rgms_pkg::NUM_WIN];
   logic [rgms_pkg::COUNT_W-1:0]  counts_ff [rgms_pkg::NUM_WIN];
   logic                          win_add;
   logic                          win_clr;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rgms_pkg::WIN_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [rgms_pkg::MEAN_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic                          rsp_load;

   // shared unit operands
   logic [SIDE_W-1:0]             win_w;
   logic [SIDE_W-1:0]             win_h;
   logic signed [CMP_W-1:0]       col_s, row_s, ox_s, oy_s, ww_s, wh_s;
   logic                          hit;
   logic [rgms_pkg::CHAN_W-1:0]   mul_chan;
   logic [rgms_pkg::COEF_W-1:0]   mul_coef;
   logic [rgms_pkg::GRAY_W-1:0]   gray;
   logic                          count_match;

   rgms_pkg::div_req_type         div_req;
   rgms_pkg::div_rsp_type         div_rsp;

   // -------------------------------------------------------------------------
   // configuration registers
   // -------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= rgms_pkg::WIDTH_RESET;
         height_ff   <= rgms_pkg::HEIGHT_RESET;
         org_x_ff[0] <= rgms_pkg::ORG_X0_RESET;
         org_y_ff[0] <= rgms_pkg::ORG_Y0_RESET;
         org_x_ff[1] <= rgms_pkg::ORG_X1_RESET;
         org_y_ff[1] <= rgms_pkg::ORG_Y1_RESET;
         org_x_ff[2] <= rgms_pkg::ORG_X2_RESET;
         org_y_ff[2] <= rgms_pkg::ORG_Y2_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rgms_pkg::CSR_WINDOW_WIDTH:    width_ff    <= csr_wdata[rgms_pkg::SIZE_W-1:0];
            rgms_pkg::CSR_WINDOW_HEIGHT:   height_ff   <= csr_wdata[rgms_pkg::SIZE_W-1:0];
            rgms_pkg::CSR_FIRST_ORIGIN_X:  org_x_ff[0] <= csr_wdata;
            rgms_pkg::CSR_FIRST_ORIGIN_Y:  org_y_ff[0] <= csr_wdata;
            rgms_pkg::CSR_SECOND_ORIGIN_X: org_x_ff[1] <= csr_wdata;
            rgms_pkg::CSR_SECOND_ORIGIN_Y: org_y_ff[1] <= csr_wdata;
            rgms_pkg::CSR_THIRD_ORIGIN_X:  org_x_ff[2] <= csr_wdata;
            rgms_pkg::CSR_THIRD_ORIGIN_Y:  org_y_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign win_w = (int'(width_ff) > MAX_WINDOW_SIDE) ? SIDE_MAX : SIDE_W'(width_ff);
   assign win_h = (int'(height_ff) > MAX_WINDOW_SIDE) ? SIDE_MAX : SIDE_W'(height_ff);

   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(win_w) * AREA_W'(win_h);
   end

   // -------------------------------------------------------------------------
   // shared datapath
   // -------------------------------------------------------------------------
   always_comb begin
      case (idx_ff)
         2'd0: begin
            mul_chan = pix_b_ff;
            mul_coef = rgms_pkg::COEF_BLUE;
         end
         2'd1: begin
            mul_chan = pix_g_ff;
            mul_coef = rgms_pkg::COEF_GREEN;
         end
         2'd2: begin
            mul_chan = pix_r_ff;
            mul_coef = rgms_pkg::COEF_RED;
         end
         default: begin
            mul_chan = '0;
            mul_coef = '0;
         end
      endcase
   end

   assign gray = acc_ff[rgms_pkg::GRAY_SHIFT +: rgms_pkg::GRAY_W];

   // window test for the window under idx_ff
   assign col_s = $signed(CMP_W'(pix_col_ff));
   assign row_s = $signed(CMP_W'(pix_row_ff));
   assign ox_s  = CMP_W'(org_x_ff[idx_ff]);
   assign oy_s  = CMP_W'(org_y_ff[idx_ff]);
   assign ww_s  = $signed(CMP_W'(win_w));
   assign wh_s  = $signed(CMP_W'(win_h));
   assign hit   = pix_in_img_ff && (col_s >= ox_s) && (col_s < ox_s + ww_s) &&
                  (row_s >= oy_s) && (row_s < oy_s + wh_s);

   assign count_match = (area_ff != '0) &&
                        (AC_W'(counts_ff[idx_ff]) == AC_W'(area_ff));

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      pix_col_in       = pix_col_ff;
      pix_row_in       = pix_row_ff;
      pix_in_img_in    = pix_in_img_ff;
      pix_frame_end_in = pix_frame_end_ff;
      pix_b_in         = pix_b_ff;
      pix_g_in         = pix_g_ff;
      pix_r_in         = pix_r_ff;
      prod_in          = prod_ff;
      acc_in           = acc_ff;
      res_ok_in        = res_ok_ff;
      mean_in          = mean_ff;
      win_add          = 1'b0;
      win_clr          = 1'b0;
      rsp_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.sum      = sums_ff[idx_ff];
      div_req.divisor  = rgms_pkg::COUNT_W'(area_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pix_b_in         = req_blue;
               pix_g_in         = req_green;
               pix_r_in         = req_red;
               pix_frame_end_in = req_frame_end;
               pix_col_in       = col_ff;
               pix_row_in       = row_ff;
               pix_in_img_in    = (col_ff < IMG_LIMIT) && (row_ff < IMG_LIMIT);
               if (req_frame_end) begin
                  col_in = '0;
                  row_in = '0;
               end else if (req_line_end) begin
                  col_in = '0;
                  if (row_ff < IMG_LIMIT) begin
                     row_in = row_ff + 1'b1;
                  end
               end else if (col_ff < IMG_LIMIT) begin
                  col_in = col_ff + 1'b1;
               end
               idx_in   = '0;
               state_in = ST_GRAY;
            end
         end
         ST_GRAY: begin
            // product of this step is added one step later
            prod_in = rgms_pkg::PROD_W'(mul_chan) * rgms_pkg::PROD_W'(mul_coef);
            if (idx_ff == '0) begin
               acc_in = rgms_pkg::GRAY_ROUND;
            end else begin
               acc_in = acc_ff + rgms_pkg::ACC_W'(prod_ff);
            end
            if (idx_ff == 2'd3) begin
               idx_in   = '0;
               state_in = ST_WIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_WIN: begin
            win_add = hit;
            if (idx_ff == rgms_pkg::LAST_WIN) begin
               idx_in   = '0;
               state_in = pix_frame_end_ff ? ST_LAUNCH : ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAUNCH: begin
            res_ok_in = count_match;
            if (count_match) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               mean_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               win_clr  = 1'b1;
               if (idx_ff == rgms_pkg::LAST_WIN) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_LAUNCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
      pix_col_ff       <= pix_col_in;
      pix_row_ff       <= pix_row_in;
      pix_in_img_ff    <= pix_in_img_in;
      pix_frame_end_ff <= pix_frame_end_in;
      pix_b_ff         <= pix_b_in;
      pix_g_ff         <= pix_g_in;
      pix_r_ff         <= pix_r_in;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      res_ok_ff        <= res_ok_in;
      mean_ff          <= mean_in;
   end

   // accumulators wrap at their width
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rgms_pkg::NUM_WIN; i++) begin
            sums_ff[i]   <= '0;
            counts_ff[i] <= '0;
         end
      end else if (win_clr) begin
         sums_ff[idx_ff]   <= '0;
         counts_ff[idx_ff] <= '0;
      end else if (win_add) begin
         sums_ff[idx_ff]   <= sums_ff[idx_ff] + rgms_pkg::SUM_W'(gray);
         counts_ff[idx_ff] <= counts_ff[idx_ff] + 1'b1;
      end
   end

   rgms_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // -------------------------------------------------------------------------
   // result register
   // -------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = idx_ff;
         rsp_mean_in  = res_ok_ff ? mean_ff : '0;
         rsp_ok_in    = res_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_idx_ff  <= rsp_idx_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_index = rsp_idx_ff;
   assign rsp_mean_gray    = rsp_mean_ff;
   assign rsp_window_valid = rsp_ok_ff;
   assign rsp_last_window  = (rsp_idx_ff == rgms_pkg::LAST_WIN);

endmodule

@@ design/rgms_div.sv @@
// ----------------------------------------------------------------------------
// rgms_div
// restoring divider, one quotient bit per cycle: floor(sum * 256 / divisor)
// ----------------------------------------------------------------------------
module rgms_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rgms_pkg::div_req_type div_req,
   output rgms_pkg::div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(rgms_pkg::MEAN_W);
   localparam int REM_W  = rgms_pkg::COUNT_W;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [rgms_pkg::MEAN_W-1:0]   low_ff, low_in;
   logic [REM_W-1:0]              dvsr_ff, dvsr_in;
   logic [rgms_pkg::MEAN_W-1:0]   quo_ff, quo_in;
   logic [REM_W:0]                trial;
   logic [REM_W:0]                diff;
   logic                          fits;

   // the result is known to fit in 16 bits, so the top bits start as remainder
   assign trial = {rem_ff, low_ff[rgms_pkg::MEAN_W-1]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign fits  = trial >= {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dvsr_in = dvsr_ff;
      quo_in  = quo_ff;
      if (busy_ff) begin
         rem_in  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         low_in  = {low_ff[rgms_pkg::MEAN_W-2:0], 1'b0};
         quo_in  = {quo_ff[rgms_pkg::MEAN_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(rgms_pkg::MEAN_W - 1);
         rem_in  = div_req.sum[rgms_pkg::SUM_W-1:rgms_pkg::FRAC_W];
         low_in  = {div_req.sum[rgms_pkg::FRAC_W-1:0], rgms_pkg::FRAC_W'(0)};
         dvsr_in = div_req.divisor;
         quo_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      dvsr_ff <= dvsr_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ design/rgms_checker.sv @@
// ----------------------------------------------------------------------------
// rgms_checker
// port-level checks of the roi gray mean statistics block
// ----------------------------------------------------------------------------
`include "roi_gray_mean_statistics_core_defines.svh"

module rgms_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rgms_pkg::WIN_IDX_W-1:0]     rsp_window_index,
   input logic [rgms_pkg::MEAN_W-1:0]        rsp_mean_gray,
   input logic                               rsp_window_valid,
   input logic                               rsp_last_window
);

   logic [rgms_pkg::WIN_IDX_W+rgms_pkg::MEAN_W:0] rsp_payload;
   logic                                          last_expected;
   logic                                          first_window;

   assign rsp_payload   = {rsp_window_index, rsp_mean_gray, rsp_window_valid};
   assign last_expected = (rsp_window_index == rgms_pkg::LAST_WIN);
   assign first_window  = (rsp_window_index == '0);

   // a stalled result item holds
   `RGMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // an invalid window reports a zero mean
   `RGMS_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_valid && !rsp_window_valid, rsp_mean_gray == '0)

   // last flag only on the third window
   `RGMS_ASSERT_IMPLY(a_last_flag, clock, reset, rsp_valid, rsp_last_window == last_expected)

   // the first window leaves the others of the frame pending, so no pixel is taken
   `RGMS_ASSERT_NEXT(a_busy_mid_frame, clock, reset, rsp_valid && rsp_ready && first_window, !req_ready)

   // a taken pixel keeps the block busy
   `RGMS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind roi_gray_mean_statistics_core rgms_checker u_rgms_checker (.*);
